// File: rtl/core/mco_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_pkg
// shared constants, codes and a helper of the midpoint circle outline block
// ----------------------------------------------------------------------------
package mco_pkg;

  localparam int COORD_BITS_DEF  = 11;
  localparam int RADIUS_BITS_DEF = 10;
  localparam int STEP_POINTS     = 8;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // bus width rounded up to whole bytes
  function automatic int byte_up(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

// File: rtl/core/midpoint_circle_outline.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_outline
// midpoint circle outline generator, integer error form
// ----------------------------------------------------------------------------
// A start item (tuser 0) loads centre and radius and emits nothing; an
// advance item (tuser 1) on an active walk produces one step of eight
// octant-symmetric points, otherwise nothing. The eighth point of each step
// carries tlast, and tuser marks the point that ends the circle. The front
// takes one item per cycle while its two-entry step queue has room; the back
// end's point sequencer sends one point per cycle while a step record is
// queued and the output is ready. Output is registered.
module midpoint_circle_outline import mco_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  localparam int IN_W  = byte_up(2 * COORD_BITS + RADIUS_BITS),
  localparam int OW    = COORD_BITS + 2,
  localparam int OUT_W = byte_up(2 * OW)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // center_x, center_y, radius
  input  logic             in_tuser,   // operation
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // point_x, point_y
  output logic             out_tlast,  // last_of_step
  output logic             out_tuser   // circle_done
);

  localparam int XW    = RADIUS_BITS + 1;
  localparam int REC_W = 2 * COORD_BITS + 2 * XW + 1;

  logic             item_fire, push_valid, push_ready, head_valid, pop;
  logic [REC_W-1:0] push_data, head_data;
  logic [OW-1:0]    point_x, point_y;

  assign in_tready = push_ready;
  assign item_fire = in_tvalid && in_tready;

  mco_front #(.COORD_BITS(COORD_BITS), .RADIUS_BITS(RADIUS_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (item_fire),
    .op         (in_tuser),
    .center_x   (in_tdata[COORD_BITS-1:0]),
    .center_y   (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .radius     (in_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  mco_queue #(.REC_W(REC_W)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  mco_back #(.COORD_BITS(COORD_BITS), .RADIUS_BITS(RADIUS_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_data    (head_data),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_of_step (out_tlast),
    .circle_done  (out_tuser)
  );

  assign out_tdata = {{(OUT_W-2*OW){1'b0}}, point_y, point_x};

endmodule

// File: rtl/core/mco_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_front
// accepts items, holds the walk state and pushes one step record per step
// ----------------------------------------------------------------------------
module mco_front import mco_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  localparam int XW    = RADIUS_BITS + 1,
  localparam int REC_W = 2 * COORD_BITS + 2 * XW + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_fire,
  input  logic                   op,
  input  logic [COORD_BITS-1:0]  center_x,
  input  logic [COORD_BITS-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0] radius,
  output logic                   push_valid,
  output logic [REC_W-1:0]       push_data
);

  localparam int TW = RADIUS_BITS + 2;
  localparam int EW = RADIUS_BITS + 4;

  logic signed [XW-1:0]        walk_x_r, walk_x_nxt;
  logic signed [XW-1:0]        walk_y_r, walk_y_nxt;
  logic [TW-1:0]               x_term_r, x_term_nxt;
  logic [TW-1:0]               y_term_r, y_term_nxt;
  logic signed [EW-1:0]        err_r, err_nxt;
  logic [RADIUS_BITS:0]        diam_r, diam_nxt;
  logic [COORD_BITS-1:0]       cx_r, cx_nxt;
  logic [COORD_BITS-1:0]       cy_r, cy_nxt;
  logic                        active_r, active_nxt;

  logic                        is_adv, can_step, step_y, step_x, done;
  logic signed [EW-1:0]        e1, e2, ty_e, tx1_e, d_e;
  logic signed [XW-1:0]        x1, y1;
  logic [TW-1:0]               tx1, ty1;
  logic [RADIUS_BITS:0]        diam_in;

  assign is_adv   = (op_t'(op) == OP_ADVANCE);
  assign can_step = active_r && (walk_x_r >= walk_y_r);

  // one walk step
  always_comb begin
    ty_e   = $signed({{(EW-TW){1'b0}}, y_term_r});
    step_y = err_r[EW-1] || (err_r == '0);
    e1     = step_y ? (err_r + ty_e) : err_r;
    y1     = walk_y_r + $signed({{(XW-1){1'b0}}, step_y});
    ty1    = step_y ? (y_term_r + TW'(2)) : y_term_r;
    step_x = !e1[EW-1] && (e1 != '0);
    tx1    = step_x ? (x_term_r + TW'(2)) : x_term_r;
    tx1_e  = $signed({{(EW-TW){1'b0}}, tx1});
    d_e    = $signed({{(EW-RADIUS_BITS-1){1'b0}}, diam_r});
    e2     = step_x ? (e1 + tx1_e - d_e) : e1;
    x1     = walk_x_r - $signed({{(XW-1){1'b0}}, step_x});
    done   = (x1 < y1);
  end

  assign diam_in = {radius, 1'b0};

  always_comb begin
    walk_x_nxt = walk_x_r;
    walk_y_nxt = walk_y_r;
    x_term_nxt = x_term_r;
    y_term_nxt = y_term_r;
    err_nxt    = err_r;
    diam_nxt   = diam_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    active_nxt = active_r;
    if (item_fire) begin
      if (!is_adv) begin
        cx_nxt     = center_x;
        cy_nxt     = center_y;
        diam_nxt   = diam_in;
        walk_x_nxt = $signed({1'b0, radius}) - XW'(1);
        walk_y_nxt = '0;
        x_term_nxt = TW'(1);
        y_term_nxt = TW'(1);
        err_nxt    = EW'(1) - $signed({{(EW-RADIUS_BITS-1){1'b0}}, diam_in});
        active_nxt = (radius != '0);
      end else if (active_r && !can_step) begin
        active_nxt = 1'b0;
      end else if (can_step) begin
        walk_x_nxt = x1;
        walk_y_nxt = y1;
        x_term_nxt = tx1;
        y_term_nxt = ty1;
        err_nxt    = e2;
        active_nxt = !done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    walk_x_r <= walk_x_nxt;
    walk_y_r <= walk_y_nxt;
    x_term_r <= x_term_nxt;
    y_term_r <= y_term_nxt;
    err_r    <= err_nxt;
    diam_r   <= diam_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
  end

  assign push_valid = item_fire && is_adv && can_step;
  assign push_data  = {done, walk_y_r, walk_x_r, cy_r, cx_r};

endmodule

// File: rtl/core/mco_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_queue
// two-entry step record queue between front and back
// ----------------------------------------------------------------------------
module mco_queue import mco_pkg::*; #(
  parameter int REC_W = 2 * COORD_BITS_DEF + 2 * (RADIUS_BITS_DEF + 1) + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [REC_W-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             head_valid,
  output logic [REC_W-1:0] head_data
);

  logic [1:0]       count_r, count_nxt;
  logic [REC_W-1:0] slot0_r, slot0_nxt;
  logic [REC_W-1:0] slot1_r, slot1_nxt;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    count_nxt = count_r;
    if (pop) begin
      slot0_nxt = slot1_r;
    end
    if (push) begin
      if (count_r == 2'd0 || (count_r == 2'd1 && pop)) begin
        slot0_nxt = push_data;
      end else begin
        slot1_nxt = push_data;
      end
    end
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign push_ready = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = slot0_r;

endmodule

// File: rtl/core/mco_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_back
// point sequencer: eight symmetric points per step record, registered output
// ----------------------------------------------------------------------------
module mco_back import mco_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  localparam int XW    = RADIUS_BITS + 1,
  localparam int REC_W = 2 * COORD_BITS + 2 * XW + 1,
  localparam int OW    = COORD_BITS + 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  logic [REC_W-1:0] head_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OW-1:0]    point_x,
  output logic [OW-1:0]    point_y,
  output logic             last_of_step,
  output logic             circle_done
);

  localparam int SW = ((COORD_BITS > XW) ? COORD_BITS : XW) + 2;
  localparam int IW = $clog2(STEP_POINTS);

  logic [IW-1:0]         idx_r, idx_nxt;
  logic                  valid_r, valid_nxt;
  logic [OW-1:0]         px_r, py_r;
  logic                  last_r, done_r;

  logic [COORD_BITS-1:0] cx, cy;
  logic [XW-1:0]         wx, wy;
  logic                  rec_done, fire, is_last;
  logic signed [SW-1:0]  cxe, cye, a, b, px, py;

  assign {rec_done, wy, wx, cy, cx} = head_data;

  assign fire    = head_valid && (!valid_r || out_ready);
  assign is_last = (idx_r == IW'(STEP_POINTS - 1));
  assign pop     = fire && is_last;

  // upper half swaps x and y, bit 1 negates the column term, bit 0 picks +row
  always_comb begin
    cxe = $signed({{(SW-COORD_BITS){1'b0}}, cx});
    cye = $signed({{(SW-COORD_BITS){1'b0}}, cy});
    a   = idx_r[2] ? $signed({{(SW-XW){wy[XW-1]}}, wy}) : $signed({{(SW-XW){wx[XW-1]}}, wx});
    b   = idx_r[2] ? $signed({{(SW-XW){wx[XW-1]}}, wx}) : $signed({{(SW-XW){wy[XW-1]}}, wy});
    px  = idx_r[1] ? (cxe - a) : (cxe + a);
    py  = idx_r[0] ? (cye + b) : (cye - b);
  end

  always_comb begin
    idx_nxt   = fire ? (idx_r + IW'(1)) : idx_r;
    valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    if (fire) begin
      px_r   <= px[OW-1:0];
      py_r   <= py[OW-1:0];
      last_r <= is_last;
      done_r <= is_last && rec_done;
    end
  end

  assign out_valid    = valid_r;
  assign point_x      = px_r;
  assign point_y      = py_r;
  assign last_of_step = last_r;
  assign circle_done  = done_r;

endmodule

// File: rtl/core/mco_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mco_checker
// port-level checks of the midpoint circle outline block
// ----------------------------------------------------------------------------
module mco_checker import mco_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  localparam int OUT_W = byte_up(2 * (COORD_BITS + 2))
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast,
  input logic             out_tuser
);

  logic [2:0] pts_r;

  // points delivered within the current step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= '0;
    end else if (out_tvalid && out_tready) begin
      pts_r <= pts_r + 3'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output item changed");

  a_last_eighth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (pts_r == 3'd7)))
    else $error("last_of_step not on the eighth point");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("circle_done without last_of_step");

endmodule

bind midpoint_circle_outline mco_checker #(
  .COORD_BITS  (COORD_BITS),
  .RADIUS_BITS (RADIUS_BITS)
) u_mco_checker (.*);
